>>> rtl/aliq_pkg.sv
// Package for the aliquot sum classifier: result widths and class codes.
// No dependencies; imported by aliquot_sum_classifier_top.
package aliq_pkg;

	// Width and saturation limit of the reported divisor sum.
	localparam int unsigned SUM_OUT_W = 23;
	localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = {SUM_OUT_W{1'b1}};

	// Classification codes.
	localparam int unsigned CLASS_W = 2;
	typedef logic [CLASS_W-1:0] class_t;
	localparam class_t CLS_DEFICIENT = 2'd0;
	localparam class_t CLS_PERFECT   = 2'd1;
	localparam class_t CLS_ABUNDANT  = 2'd2;

endpackage

>>> rtl/aliquot_sum_classifier_top.sv
// Aliquot sum classifier: sums the proper divisors of a number by trial division.
// Depends on aliq_pkg for the result width and the class codes.
//
// Usage:
// A transaction is accepted at a rising edge where start is high and busy is low;
// number is sampled at that edge. The block then runs alone until the result is
// ready: busy stays high and further starts are ignored.
// Each candidate divisor d (2, 3, ... while d*d <= number) passes through a bound
// check, a radix-4 restoring divider that yields two quotient bits per cycle, and
// an accumulate step. The shared divider sets the rate. Inputs 0 to 3 finish
// without entering the divider.
// The result is held on divisor_sum and abundance_class until the next result;
// done marks it, high for exactly one cycle, and the receiver cannot stall it.
// A new transaction can be accepted in that same cycle.
// divisor_sum saturates at its 23-bit maximum; the class uses the full sum.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops done.
module aliquot_sum_classifier_top
	import aliq_pkg::*;
#(
	parameter int unsigned NUMBER_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   done,
	output logic [SUM_OUT_W-1:0]   divisor_sum,
	output logic [CLASS_W-1:0]     abundance_class
);

	// Derived widths.
	localparam int unsigned NB     = NUMBER_BITS;
	localparam int unsigned PW     = NB + (NB % 2);
	localparam int unsigned STEPS  = PW / 2;
	localparam int unsigned CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int unsigned DW     = (NB + 1) / 2 + 1;
	localparam int unsigned SQW    = NB + 2;
	localparam int unsigned SUM_W  = NB + 3;
	localparam int unsigned EXT_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]           state_q;
	logic [NB-1:0]        n_q;
	logic [DW-1:0]        d_q;
	logic [SQW-1:0]       sq_q;
	logic [DW-1:0]        rem_q;
	logic [PW-1:0]        work_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 done_q;
	logic [SUM_OUT_W-1:0] sum_out_q;
	class_t               class_q;

	// Radix-4 restoring divider step: two conditional subtracts of the divisor.
	logic [DW:0]   r1, r1s, r2, r2s;
	logic          q1, q0;
	logic [NB-1:0] cofactor;
	logic          co_is_d;
	logic [EXT_W-1:0] sum_ext, n_ext;

	always_comb begin
		r1  = {rem_q, work_q[PW-1]};
		q1  = (r1 >= {1'b0, d_q});
		r1s = q1 ? (r1 - {1'b0, d_q}) : r1;
		r2  = {r1s[DW-1:0], work_q[PW-2]};
		q0  = (r2 >= {1'b0, d_q});
		r2s = q0 ? (r2 - {1'b0, d_q}) : r2;
	end

	// The quotient left in the work register is the cofactor n / d.
	assign cofactor = work_q[NB-1:0];
	assign co_is_d  = (cofactor == NB'(d_q));

	// Widened operands for classification and saturation.
	assign sum_ext = EXT_W'(sum_q);
	assign n_ext   = EXT_W'(n_q);

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q  <= number;
						d_q  <= DW'(2);
						sq_q <= SQW'(4);
						if (number < NB'(2)) begin
							sum_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							sum_q   <= SUM_W'(1);
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (sq_q > SQW'(n_q)) begin
						state_q <= ST_FIN;
					end else begin
						work_q  <= PW'(n_q);
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					work_q <= {work_q[PW-3:0], q1, q0};
					rem_q  <= r2s[DW-1:0];
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// A divisor adds itself and its cofactor, the cofactor only once.
					if (rem_q == '0) begin
						sum_q <= sum_q + SUM_W'(d_q)
							+ (co_is_d ? '0 : SUM_W'(cofactor));
					end
					d_q     <= d_q + DW'(1);
					sq_q    <= sq_q + SQW'({d_q, 1'b0}) + SQW'(1);
					state_q <= ST_CHK;
				end
				ST_FIN: begin
					// Saturate the reported sum; classify on the full sum.
					sum_out_q <= (sum_ext > EXT_W'(SUM_OUT_MAX))
						? SUM_OUT_MAX : SUM_OUT_W'(sum_ext);
					priority if (n_q == '0 || sum_ext < n_ext) begin
						class_q <= CLS_DEFICIENT;
					end else if (sum_ext == n_ext) begin
						class_q <= CLS_PERFECT;
					end else begin
						class_q <= CLS_ABUNDANT;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output ports.
	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign divisor_sum     = sum_out_q;
	assign abundance_class = class_q;

endmodule
